### rtl/ukf_pkg.sv
// Shared types, constants and status codes of the unique-key FIFO.
`default_nettype none
package ukf_pkg;

    localparam int DEPTH      = 16;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 32;

    typedef enum logic [2:0] {
        ST_ENQ   = 3'd0,
        ST_DUP   = 3'd1,
        ST_FULL  = 3'd2,
        ST_DEQ   = 3'd3,
        ST_EMPTY = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DEQ_RD,
        S_FINISH
    } t_state;

    typedef enum logic {
        REQ_ENQ = 1'b0,
        REQ_DEQ = 1'b1
    } t_req;

    typedef struct packed {
        t_req               req_type;
        logic [15:0]        in_key;
        logic signed [31:0] in_value;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [15:0]        out_key;
        logic signed [31:0] out_value;
        logic [4:0]         occupancy;
        logic               is_empty;
    } t_out_item;

endpackage
`default_nettype wire

### rtl/ukf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ukf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### rtl/unique_key_fifo_unit.sv
// Sequence: an enqueue walks S_SEARCH over the stored entries before S_FINISH, a dequeue reads
// the head entry in S_DEQ_RD before S_FINISH, and any request to an empty queue goes straight to S_FINISH.
// No new request is taken until the result is registered, which S_FINISH holds off while the output
// stalls; the key search reads one stored entry per cycle through the single RAM read port.
// Reset: synchronous, active low; clears head, tail, count and the sequencer.
// Store contents are not cleared; only occupied slots are ever read.
`default_nettype none
module unique_key_fifo_unit #(
    parameter int DEPTH      = ukf_pkg::DEPTH,
    parameter int KEY_BITS   = ukf_pkg::KEY_BITS,
    parameter int VALUE_BITS = ukf_pkg::VALUE_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire ukf_pkg::t_in_item i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output ukf_pkg::t_out_item    o_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = KEY_BITS + VALUE_BITS;

    ukf_pkg::t_state      r_state, n_state;
    logic [AW-1:0]        r_head, n_head;
    logic [AW-1:0]        r_tail, n_tail;
    logic [CW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_ptr, n_ptr;
    logic [CW-1:0]        r_left, n_left;
    logic                 r_pend, n_pend;
    logic                 r_dup, n_dup;
    ukf_pkg::t_req        r_req, n_req;
    logic [KEY_BITS-1:0]  r_key, n_key;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic                 r_out_valid, n_out_valid;
    ukf_pkg::t_out_item   r_out, n_out;

    logic                 w_we;
    logic                 w_re;
    logic [AW-1:0]        w_raddr;
    logic [WW-1:0]        w_rdata;
    logic [KEY_BITS-1:0]  w_rd_key;
    logic signed [VALUE_BITS-1:0] w_rd_val;
    logic [63:0]          w_in_key_wide;
    logic [63:0]          w_in_val_wide;
    logic [63:0]          w_key_wide;
    logic [63:0]          w_val_wide;
    logic [31:0]          w_occ_wide;

    assign w_rd_key      = w_rdata[WW-1 -: KEY_BITS];
    assign w_rd_val      = w_rdata[VALUE_BITS-1:0];
    assign w_in_key_wide = 64'(i_in.in_key);
    assign w_in_val_wide = 64'($unsigned(i_in.in_value));
    assign w_key_wide    = 64'(w_rd_key);
    assign w_val_wide    = 64'(w_rd_val);
    assign w_occ_wide    = 32'(n_count);

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
        next_slot = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    ukf_ram #(
        .WIDTH(WW),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_tail),
        .i_wdata({r_key, r_val}),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ukf_pkg::S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
        r_ptr  <= n_ptr;
        r_left <= n_left;
        r_dup  <= n_dup;
        r_req  <= n_req;
        r_key  <= n_key;
        r_val  <= n_val;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_left      = r_left;
        n_pend      = r_pend;
        n_dup       = r_dup;
        n_req       = r_req;
        n_key       = r_key;
        n_val       = r_val;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_raddr     = r_head;
        o_in_stall  = (r_state != ukf_pkg::S_IDLE);

        unique case (r_state)
            ukf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_req  = i_in.req_type;
                    n_key  = w_in_key_wide[KEY_BITS-1:0];
                    n_val  = w_in_val_wide[VALUE_BITS-1:0];
                    n_dup  = 1'b0;
                    n_pend = 1'b0;
                    n_ptr  = r_head;
                    n_left = r_count;
                    if (r_count == '0) begin
                        n_state = ukf_pkg::S_FINISH;
                    end else if (i_in.req_type == ukf_pkg::REQ_ENQ) begin
                        n_state = ukf_pkg::S_SEARCH;
                    end else begin
                        n_state = ukf_pkg::S_DEQ_RD;
                    end
                end
            end
            ukf_pkg::S_SEARCH: begin
                w_raddr = r_ptr;
                n_dup   = r_dup || (r_pend && (w_rd_key == r_key));
                if (r_left != '0) begin
                    w_re   = 1'b1;
                    n_ptr  = next_slot(r_ptr);
                    n_left = r_left - CW'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = ukf_pkg::S_FINISH;
                end
            end
            ukf_pkg::S_DEQ_RD: begin
                w_re    = 1'b1;
                n_state = ukf_pkg::S_FINISH;
            end
            ukf_pkg::S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.out_key   = '0;
                    n_out.out_value = '0;
                    if (r_req == ukf_pkg::REQ_ENQ) begin
                        if (r_dup) begin
                            n_out.status = ukf_pkg::ST_DUP;
                        end else if (r_count == CW'(DEPTH)) begin
                            n_out.status = ukf_pkg::ST_FULL;
                        end else begin
                            w_we         = 1'b1;
                            n_tail       = next_slot(r_tail);
                            n_count      = r_count + CW'(1);
                            n_out.status = ukf_pkg::ST_ENQ;
                        end
                    end else if (r_count == '0) begin
                        n_out.status = ukf_pkg::ST_EMPTY;
                    end else begin
                        n_head          = next_slot(r_head);
                        n_count         = r_count - CW'(1);
                        n_out.status    = ukf_pkg::ST_DEQ;
                        n_out.out_key   = w_key_wide[15:0];
                        n_out.out_value = w_val_wide[31:0];
                    end
                    n_out.occupancy = w_occ_wide[4:0];
                    n_out.is_empty  = (n_count == '0);
                    n_out_valid     = 1'b1;
                    n_state         = ukf_pkg::S_IDLE;
                end
            end
            default: n_state = ukf_pkg::S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

### rtl/ukf_checker.sv
// Port-level checks of the unique-key FIFO and their binding to the top level.
`default_nettype none
module ukf_port_checks #(
    parameter int DEPTH = ukf_pkg::DEPTH
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire ukf_pkg::t_out_item o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while previous one in work");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.is_empty == (o_out.occupancy == 5'd0)))
        else $error("empty flag disagrees with occupancy");

    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != ukf_pkg::ST_DEQ)
        |-> (o_out.out_key == '0) && (o_out.out_value == '0))
        else $error("nonzero payload on non-dequeue result");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out.occupancy) <= 32'(DEPTH)))
        else $error("occupancy above depth");

endmodule

bind unique_key_fifo_unit ukf_port_checks #(
    .DEPTH(DEPTH)
) u_ukf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out      (o_out)
);
`default_nettype wire
